// ----- design/wbc_pkg.sv -----
// shared types and constants for the workload bottleneck classifier
package wbc_pkg;

  typedef enum logic [2:0] {
    VERDICT_UNKNOWN    = 3'd0,
    VERDICT_GPU        = 3'd1,
    VERDICT_CPU        = 3'd2,
    VERDICT_CONTENTION = 3'd3,
    VERDICT_MEMORY     = 3'd4,
    VERDICT_IO         = 3'd5,
    VERDICT_MIXED      = 3'd6
  } verdict_t;

  typedef struct packed {
    logic [9:0]  game_cpu_ewma;
    logic        idle_flag;
    logic [9:0]  demand;
    logic [9:0]  stability;
    logic        sustained_heavy;
    logic [11:0] contention;
    logic [9:0]  system_cpu;
    logic [9:0]  background_cpu;
    logic [9:0]  game_cpu_now;
    logic [19:0] working_set;
    logic [39:0] read_rate;
    logic [39:0] write_rate;
  } sample_t;

  typedef struct packed {
    verdict_t   verdict;
    logic [9:0] confidence;
    logic       needs_action;
  } result_t;

  localparam logic [9:0]  MIN_CONF_RESET = 10'd650;

  // byte rate thresholds, MB = 2^20 bytes
  localparam logic [39:0] RATE_100MB = 40'd104857600;
  localparam logic [39:0] RATE_50MB  = 40'd52428800;
  localparam logic [40:0] RATE_CAP   = 41'd419430400;

  // reciprocals for the constant divides
  localparam logic [10:0] RECIP_DIV7 = 11'd1171;  // ceil(2^13 / 7)
  localparam logic [9:0]  RECIP_DIV5 = 10'd820;   // ceil(2^12 / 5)

endpackage

// ----- design/wbc_classify.sv -----
// rule chain: one sample in, verdict, confidence and action flag out
module wbc_classify (
  input  wbc_pkg::sample_t smp,
  input  logic [9:0]       min_conf,
  output wbc_pkg::result_t res
);

  // gpu: 250*(350-ewma)/350 = floor(5*d/7)
  logic [7:0]  gpu_diff;
  logic [9:0]  gpu_n;
  logic [20:0] gpu_prod;
  logic [9:0]  gpu_conf;

  // memory: 150*(ws-2048)/2048
  logic [19:0] mem_diff;
  logic [27:0] mem_prod;
  logic [9:0]  mem_base;
  logic [17:0] mem_sum;
  logic [9:0]  mem_conf;

  // io: 180*s/(400 MB) = floor(floor(9*s / 2^20) / 4 / 5)
  logic [40:0] io_sum;
  logic [28:0] io_s;
  logic [32:0] io_9s;
  logic [9:0]  io_u;
  logic [19:0] io_prod;
  logic [9:0]  io_conf;

  logic [9:0]  cpu_conf;
  logic [9:0]  cont_conf;
  logic [2:0]  mix_cnt;

  logic        is_idle, is_gpu, is_cpu, is_cont, is_mem, is_io;
  logic        actionable;

  always_comb begin
    gpu_diff = 8'(10'd350 - smp.game_cpu_ewma);
    gpu_n    = {gpu_diff, 2'b00} + {2'b00, gpu_diff};
    gpu_prod = 21'(gpu_n) * 21'(wbc_pkg::RECIP_DIV7);
    gpu_conf = 10'd400 + {2'b00, gpu_prod[20:13]};

    mem_diff = smp.working_set - 20'd2048;
    mem_prod = 28'(mem_diff) * 28'd150;
    mem_base = (smp.stability < 10'd500) ? 10'd400 : 10'd450;
    mem_sum  = 18'(mem_base) + {1'b0, mem_prod[27:11]};
    mem_conf = (mem_sum > 18'd700) ? 10'd700 : mem_sum[9:0];

    io_sum  = {1'b0, smp.read_rate} + {1'b0, smp.write_rate};
    io_s    = (io_sum > wbc_pkg::RATE_CAP) ? wbc_pkg::RATE_CAP[28:0] : io_sum[28:0];
    io_9s   = {1'b0, io_s, 3'b000} + {4'b0000, io_s};
    io_u    = io_9s[31:22];
    io_prod = 20'(io_u) * 20'(wbc_pkg::RECIP_DIV5);
    io_conf = 10'd500 + {2'b00, io_prod[19:12]};

    cpu_conf = 10'd600;
    if (smp.demand > 10'd800)  cpu_conf = cpu_conf + 10'd200;
    if (smp.stability > 10'd700) cpu_conf = cpu_conf + 10'd80;
    if (smp.sustained_heavy)   cpu_conf = cpu_conf + 10'd40;

    cont_conf = 10'd500;
    if (smp.contention > 12'd600) cont_conf = cont_conf + 10'd250;
    if (smp.demand > 10'd400)     cont_conf = cont_conf + 10'd100;

    mix_cnt = 3'(smp.demand >= 10'd450) + 3'(smp.contention >= 12'd280)
            + 3'(smp.read_rate >= wbc_pkg::RATE_50MB) + 3'(smp.working_set >= 20'd1536);

    is_idle = smp.game_cpu_ewma < 10'd150;
    is_gpu  = (smp.game_cpu_ewma < 10'd350) && (smp.system_cpu < 10'd450) && !smp.idle_flag;
    is_cpu  = (smp.demand >= 10'd680) && (smp.system_cpu >= 10'd650)
           && (smp.background_cpu <= 10'd300);
    is_cont = (smp.contention >= 12'd420) && (smp.demand >= 10'd280)
           && (smp.demand <= 10'd750);
    is_mem  = (smp.working_set >= 20'd2048) && (smp.game_cpu_now < 10'd550);
    is_io   = ((smp.read_rate >= wbc_pkg::RATE_100MB) || (smp.write_rate >= wbc_pkg::RATE_50MB))
           && (smp.demand >= 10'd200) && (smp.demand <= 10'd700)
           && (smp.game_cpu_now < 10'd600);

    res.needs_action = 1'b0;
    if (is_idle) begin
      res.verdict    = wbc_pkg::VERDICT_UNKNOWN;
      res.confidence = 10'd900;
    end else if (is_gpu) begin
      res.verdict    = wbc_pkg::VERDICT_GPU;
      res.confidence = gpu_conf;
    end else if (is_cpu) begin
      res.verdict    = wbc_pkg::VERDICT_CPU;
      res.confidence = cpu_conf;
    end else if (is_cont) begin
      res.verdict    = wbc_pkg::VERDICT_CONTENTION;
      res.confidence = cont_conf;
    end else if (is_mem) begin
      res.verdict    = wbc_pkg::VERDICT_MEMORY;
      res.confidence = mem_conf;
    end else if (is_io) begin
      res.verdict    = wbc_pkg::VERDICT_IO;
      res.confidence = io_conf;
    end else if (mix_cnt >= 3'd2) begin
      res.verdict    = wbc_pkg::VERDICT_MIXED;
      res.confidence = 10'd350 + (10'(mix_cnt) * 10'd50);
      if (res.confidence > 10'd550) res.confidence = 10'd550;
    end else begin
      res.verdict    = wbc_pkg::VERDICT_UNKNOWN;
      res.confidence = 10'd200;
    end

    actionable = (res.verdict == wbc_pkg::VERDICT_CPU)
              || (res.verdict == wbc_pkg::VERDICT_CONTENTION)
              || (res.verdict == wbc_pkg::VERDICT_IO);
    res.needs_action = actionable && (res.confidence >= min_conf);
  end

endmodule

// ----- design/workload_bottleneck_classifier_unit.sv -----
// top level of the workload bottleneck classifier
//
// usage:
//   input channel: drive the sample fields on in_* and raise start; the sample
//   is taken at every rising edge where start is high and busy is low. busy is
//   low whenever the block is out of reset, so a new sample can go in on every
//   cycle.
//   result channel: out_valid marks one cycle in which out_verdict,
//   out_confidence and out_needs_action hold the result of one sample. results
//   come out in input order, one per sample.
//   config channel: cfg_valid/cfg_ready with cfg_data writes the action
//   threshold (min_confidence); cfg_ready is always high out of reset. write it
//   only while no sample is in flight.
// timing: an accepted sample sits in the input register, is classified from
//   there by the rule chain, and its result is shown from the result register.
//   throughput is one sample per cycle; the only work per sample is the rule
//   chain between the input and result registers.
// reset: rst_n low clears the pipeline valid bits and sets the threshold to 650;
//   busy and !cfg_ready stay high during reset.
// the receiver cannot stall: every result is presented for exactly one cycle.
module workload_bottleneck_classifier_unit (
  input  logic        clk,
  input  logic        rst_n,
  // sample input
  input  logic        start,
  output logic        busy,
  input  logic [9:0]  in_game_cpu_ewma,
  input  logic        in_idle_flag,
  input  logic [9:0]  in_demand,
  input  logic [9:0]  in_stability,
  input  logic        in_sustained_heavy,
  input  logic [11:0] in_contention,
  input  logic [9:0]  in_system_cpu,
  input  logic [9:0]  in_background_cpu,
  input  logic [9:0]  in_game_cpu_now,
  input  logic [19:0] in_working_set,
  input  logic [39:0] in_read_rate,
  input  logic [39:0] in_write_rate,
  // result output
  output logic        out_valid,
  output logic [2:0]  out_verdict,
  output logic [9:0]  out_confidence,
  output logic        out_needs_action,
  // threshold register write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [9:0]  cfg_data
);

  // input stage
  logic             in_vld_r, in_vld_nxt;
  wbc_pkg::sample_t smp_r, smp_nxt;

  // result stage
  logic             out_vld_r, out_vld_nxt;
  wbc_pkg::result_t res_r;
  wbc_pkg::result_t res_nxt;

  // threshold register
  logic [9:0]       min_conf_r, min_conf_nxt;

  logic             in_xfer;

  // busy only while in reset so that no transfer is taken then
  assign busy      = !rst_n;
  assign cfg_ready = rst_n;
  assign in_xfer   = start && !busy;

  always_comb begin
    in_vld_nxt = in_xfer;
    smp_nxt    = smp_r;
    if (in_xfer) begin
      smp_nxt.game_cpu_ewma   = in_game_cpu_ewma;
      smp_nxt.idle_flag       = in_idle_flag;
      smp_nxt.demand          = in_demand;
      smp_nxt.stability       = in_stability;
      smp_nxt.sustained_heavy = in_sustained_heavy;
      smp_nxt.contention      = in_contention;
      smp_nxt.system_cpu      = in_system_cpu;
      smp_nxt.background_cpu  = in_background_cpu;
      smp_nxt.game_cpu_now    = in_game_cpu_now;
      smp_nxt.working_set     = in_working_set;
      smp_nxt.read_rate       = in_read_rate;
      smp_nxt.write_rate      = in_write_rate;
    end
    out_vld_nxt  = in_vld_r;
    min_conf_nxt = (cfg_valid && cfg_ready) ? cfg_data : min_conf_r;
  end

  // the whole rule chain sits between the two register stages
  wbc_classify u_classify (
    .smp      (smp_r),
    .min_conf (min_conf_r),
    .res      (res_nxt)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r   <= 1'b0;
      out_vld_r  <= 1'b0;
      min_conf_r <= wbc_pkg::MIN_CONF_RESET;
    end else begin
      in_vld_r   <= in_vld_nxt;
      out_vld_r  <= out_vld_nxt;
      min_conf_r <= min_conf_nxt;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    smp_r <= smp_nxt;
    if (in_vld_r) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_verdict      = res_r.verdict;
  assign out_confidence   = res_r.confidence;
  assign out_needs_action = res_r.needs_action;

  // every accepted sample produces a result, through the input and result registers
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> ##1 out_valid)
    else $error("accepted sample did not produce a result");

  // action only for cpu, contention or io verdicts
  a_action_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_needs_action) |->
      (out_verdict == wbc_pkg::VERDICT_CPU || out_verdict == wbc_pkg::VERDICT_CONTENTION ||
       out_verdict == wbc_pkg::VERDICT_IO))
    else $error("action flagged for a non-actionable verdict");

  // unknown verdict comes only from the idle or default rule
  a_unknown_conf: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_verdict == wbc_pkg::VERDICT_UNKNOWN) |->
      (out_confidence == 10'd900 || out_confidence == 10'd200))
    else $error("unknown verdict with unexpected confidence");

endmodule

// ----- tb/sv/testbench.sv -----
// self-checking testbench for the workload bottleneck classifier unit
`timescale 1ns / 100ps

// holds the expected verdicts of accepted samples, in input order
class verdict_scoreboard;
  logic [9:0]        action_floor;
  wbc_pkg::result_t  pending_verdicts[$];
  int unsigned       errors;
  int unsigned       accepted;
  int unsigned       checked;
  int unsigned       actions;
  int unsigned       verdict_hits[7];

  localparam longint unsigned MEBI = 64'd1048576;

  function new();
    action_floor = wbc_pkg::MIN_CONF_RESET;
    errors = 0;
    accepted = 0;
    checked = 0;
    actions = 0;
    foreach (verdict_hits[i]) verdict_hits[i] = 0;
  endfunction

  function void set_floor(logic [9:0] v);
    action_floor = v;
  endfunction

  function int unsigned pending();
    return pending_verdicts.size();
  endfunction

  // priority rule chain, first match decides
  function wbc_pkg::result_t classify_sample(wbc_pkg::sample_t s);
    wbc_pkg::result_t  r;
    wbc_pkg::verdict_t v;
    int unsigned       conf;
    int unsigned       signals;
    int unsigned       ewma, demand, stab, cont, sys, bg, gnow, ws;
    longint unsigned   rd, wr, io_sum;
    ewma   = s.game_cpu_ewma;
    demand = s.demand;
    stab   = s.stability;
    cont   = s.contention;
    sys    = s.system_cpu;
    bg     = s.background_cpu;
    gnow   = s.game_cpu_now;
    ws     = s.working_set;
    rd     = s.read_rate;
    wr     = s.write_rate;
    v      = wbc_pkg::VERDICT_UNKNOWN;
    conf   = 200;
    if (ewma < 150) begin
      conf = 900;
    end else if (ewma < 350 && sys < 450 && !s.idle_flag) begin
      v = wbc_pkg::VERDICT_GPU;
      conf = 400 + (250 * (350 - ewma)) / 350;
      if (conf > 650) conf = 650;
    end else if (demand >= 680 && sys >= 650 && bg <= 300) begin
      v = wbc_pkg::VERDICT_CPU;
      conf = 600;
      if (demand > 800) conf += 200;
      if (stab > 700) conf += 80;
      if (s.sustained_heavy) conf += 40;
      if (conf > 920) conf = 920;
    end else if (cont >= 420 && demand >= 280 && demand <= 750) begin
      v = wbc_pkg::VERDICT_CONTENTION;
      conf = 500;
      if (cont > 600) conf += 250;
      if (demand > 400) conf += 100;
      if (conf > 850) conf = 850;
    end else if (ws >= 2048 && gnow < 550) begin
      v = wbc_pkg::VERDICT_MEMORY;
      conf = ((stab < 500) ? 400 : 450) + (150 * (ws - 2048)) / 2048;
      if (conf < 400) conf = 400;
      if (conf > 700) conf = 700;
    end else if ((rd >= 100 * MEBI || wr >= 50 * MEBI) &&
                 demand >= 200 && demand <= 700 && gnow < 600) begin
      v = wbc_pkg::VERDICT_IO;
      io_sum = rd + wr;
      if (io_sum > 400 * MEBI) io_sum = 400 * MEBI;
      conf = 500 + int'((64'd180 * io_sum) / (400 * MEBI));
      if (conf > 680) conf = 680;
    end else begin
      signals = 0;
      if (demand >= 450) signals++;
      if (cont >= 280) signals++;
      if (rd >= 50 * MEBI) signals++;
      if (ws >= 1536) signals++;
      if (signals >= 2) begin
        v = wbc_pkg::VERDICT_MIXED;
        conf = 350 + 50 * signals;
        if (conf > 550) conf = 550;
      end
    end
    r.verdict      = v;
    r.confidence   = conf[9:0];
    r.needs_action = (v == wbc_pkg::VERDICT_CPU || v == wbc_pkg::VERDICT_CONTENTION ||
                      v == wbc_pkg::VERDICT_IO) && conf >= action_floor;
    return r;
  endfunction

  function void note_sample(wbc_pkg::sample_t s);
    pending_verdicts.push_back(classify_sample(s));
    accepted++;
  endfunction

  task report(string msg);
    $display("MISMATCH: %s", msg);
    errors++;
  endtask

  task check_result(logic [2:0] verdict, logic [9:0] conf, logic act);
    wbc_pkg::result_t want;
    if (pending_verdicts.size() == 0) begin
      report($sformatf("result %0d/%0d/%0d with no sample outstanding", verdict, conf, act));
      return;
    end
    want = pending_verdicts.pop_front();
    checked++;
    verdict_hits[int'(want.verdict)]++;
    if (want.needs_action) actions++;
    if (verdict !== want.verdict)
      report($sformatf("result %0d: verdict %0d, expected %0d", checked, verdict, want.verdict));
    if (conf !== want.confidence)
      report($sformatf("result %0d: confidence %0d, expected %0d", checked, conf,
                       want.confidence));
    if (act !== want.needs_action)
      report($sformatf("result %0d: needs_action %0d, expected %0d", checked, act,
                       want.needs_action));
  endtask
endclass

module testbench;
  localparam int unsigned     CYCLE_LIMIT  = 200000;
  localparam int unsigned     PHASE_ITEMS  = 170;
  localparam int unsigned     IDLE_PCT     = 13;
  localparam longint unsigned MEBI         = 64'd1048576;
  localparam int unsigned     DIRECTED_N   = 21;
  localparam int unsigned     PHASES       = 6;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [9:0]  in_game_cpu_ewma;
  logic        in_idle_flag;
  logic [9:0]  in_demand;
  logic [9:0]  in_stability;
  logic        in_sustained_heavy;
  logic [11:0] in_contention;
  logic [9:0]  in_system_cpu;
  logic [9:0]  in_background_cpu;
  logic [9:0]  in_game_cpu_now;
  logic [19:0] in_working_set;
  logic [39:0] in_read_rate;
  logic [39:0] in_write_rate;
  logic        out_valid;
  logic [2:0]  out_verdict;
  logic [9:0]  out_confidence;
  logic        out_needs_action;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [9:0]  cfg_data;

  verdict_scoreboard sb;
  int unsigned       cycle_count;
  logic [9:0]        floors [PHASES];

  workload_bottleneck_classifier_unit dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_game_cpu_ewma   (in_game_cpu_ewma),
    .in_idle_flag       (in_idle_flag),
    .in_demand          (in_demand),
    .in_stability       (in_stability),
    .in_sustained_heavy (in_sustained_heavy),
    .in_contention      (in_contention),
    .in_system_cpu      (in_system_cpu),
    .in_background_cpu  (in_background_cpu),
    .in_game_cpu_now    (in_game_cpu_now),
    .in_working_set     (in_working_set),
    .in_read_rate       (in_read_rate),
    .in_write_rate      (in_write_rate),
    .out_valid          (out_valid),
    .out_verdict        (out_verdict),
    .out_confidence     (out_confidence),
    .out_needs_action   (out_needs_action),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_data           (cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watch all three channels; values read here are the ones from before the edge
  always @(posedge clk) begin
    if (rst_n && start && !busy)
      sb.note_sample({in_game_cpu_ewma, in_idle_flag, in_demand, in_stability,
                      in_sustained_heavy, in_contention, in_system_cpu,
                      in_background_cpu, in_game_cpu_now, in_working_set,
                      in_read_rate, in_write_rate});
    if (rst_n && out_valid)
      sb.check_result(out_verdict, out_confidence, out_needs_action);
    if (rst_n && cfg_valid && cfg_ready)
      sb.set_floor(cfg_data);
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("workload_bottleneck_classifier_unit verification failed");
      $finish;
    end
  end

  // hold the sample on the ports until the transfer happens
  task automatic send_sample(wbc_pkg::sample_t s);
    in_game_cpu_ewma   <= s.game_cpu_ewma;
    in_idle_flag       <= s.idle_flag;
    in_demand          <= s.demand;
    in_stability       <= s.stability;
    in_sustained_heavy <= s.sustained_heavy;
    in_contention      <= s.contention;
    in_system_cpu      <= s.system_cpu;
    in_background_cpu  <= s.background_cpu;
    in_game_cpu_now    <= s.game_cpu_now;
    in_working_set     <= s.working_set;
    in_read_rate       <= s.read_rate;
    in_write_rate      <= s.write_rate;
    start              <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  task automatic hold_off(int unsigned cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // stop sending and let every outstanding result come back, plus pipeline slack
  task automatic drain();
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_floor(logic [9:0] v);
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [39:0] rate_around(longint unsigned center);
    longint unsigned r;
    r = center - 24 * MEBI + longint'($urandom_range(0, 48 * 1048576));
    return r[39:0];
  endfunction

  function automatic logic [39:0] rate_below(int unsigned mb);
    return 40'($urandom_range(0, mb * 1048576 - 1));
  endfunction

  // edge cases of each rule, on top of a sample that falls through to unknown
  function automatic wbc_pkg::sample_t directed_sample(int unsigned idx);
    wbc_pkg::sample_t s;
    s = '0;
    s.game_cpu_ewma  = 10'd500;
    s.demand         = 10'd100;
    s.system_cpu     = 10'd500;
    s.background_cpu = 10'd500;
    s.game_cpu_now   = 10'd900;
    case (idx)
      0:  s = '0;                                       // all zero, idle
      1:  begin s.game_cpu_ewma = 10'd149; s.idle_flag = 1'b1; end
      2:  begin s.game_cpu_ewma = 10'd150; s.system_cpu = 10'd0; end
      3:  begin s.game_cpu_ewma = 10'd349; s.system_cpu = 10'd449; end
      4:  begin                                         // idle flag blocks gpu only
        s.game_cpu_ewma = 10'd200; s.system_cpu = 10'd0; s.idle_flag = 1'b1;
      end
      5:  begin
        s.demand = 10'd1023; s.system_cpu = 10'd1023; s.background_cpu = 10'd0;
        s.stability = 10'd1023; s.sustained_heavy = 1'b1;
      end
      6:  begin s.demand = 10'd680; s.system_cpu = 10'd650; s.background_cpu = 10'd300; end
      7:  begin s.contention = 12'd4095; s.demand = 10'd750; end
      8:  begin s.contention = 12'd420; s.demand = 10'd280; end
      9:  begin s.working_set = 20'd2048; s.game_cpu_now = 10'd549; end
      10: begin
        s.working_set = 20'hFFFFF; s.stability = 10'd1023; s.game_cpu_now = 10'd0;
      end
      11: begin
        s.read_rate = '1; s.write_rate = '1; s.demand = 10'd500; s.game_cpu_now = 10'd0;
      end
      12: begin
        s.write_rate = 40'(50 * MEBI); s.demand = 10'd200; s.game_cpu_now = 10'd599;
      end
      13: begin
        s.read_rate = 40'(100 * MEBI); s.demand = 10'd700; s.game_cpu_now = 10'd0;
      end
      14: begin                                        // all four mixed signals
        s.demand = 10'd450; s.contention = 12'd280;
        s.read_rate = 40'(50 * MEBI); s.working_set = 20'd1536;
      end
      15: begin s.demand = 10'd1023; s.working_set = 20'd1536; end
      16: begin                                        // one short of every signal
        s.demand = 10'd449; s.contention = 12'd279;
        s.read_rate = 40'(50 * MEBI - 1); s.working_set = 20'd1535;
      end
      17: s = '1;                                       // every field saturated
      18: begin s.working_set = 20'd4096; s.game_cpu_now = 10'd550; end
      19: begin s.read_rate = '1; s.demand = 10'd199; s.game_cpu_now = 10'd0; end
      default: begin
        s.working_set = 20'd4096; s.stability = 10'd500; s.game_cpu_now = 10'd0;
      end
    endcase
    return s;
  endfunction

  // random sample aimed at one rule, with full-range noise underneath
  function automatic wbc_pkg::sample_t random_sample();
    wbc_pkg::sample_t s;
    logic [191:0]     raw;
    int unsigned      aim;
    int unsigned      flavor;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    s = raw[$bits(wbc_pkg::sample_t)-1:0];
    aim = $urandom_range(0, 9);
    if (aim >= 4) begin
      s.game_cpu_ewma = 10'($urandom_range(340, 1023));
      s.system_cpu    = 10'($urandom_range(380, 1023));
    end
    case (aim)
      2: s.game_cpu_ewma = 10'($urandom_range(0, 170));
      3: begin
        s.game_cpu_ewma = 10'($urandom_range(130, 370));
        s.system_cpu    = 10'($urandom_range(0, 470));
        s.idle_flag     = ($urandom_range(0, 3) == 0);
      end
      4: begin
        s.demand         = 10'($urandom_range(660, 1023));
        s.system_cpu     = 10'($urandom_range(630, 1023));
        s.background_cpu = 10'($urandom_range(0, 320));
      end
      5: begin
        s.contention = 12'($urandom_range(0, 1) ? $urandom_range(400, 650)
                                                 : $urandom_range(400, 4095));
        s.demand     = 10'($urandom_range(260, 770));
      end
      6: begin
        s.demand       = 10'($urandom_range(0, 600));
        s.contention   = 12'($urandom_range(0, 440));
        if ($urandom_range(0, 3) != 0) s.working_set = 20'($urandom_range(2000, 6200));
        s.game_cpu_now = 10'($urandom_range(0, 570));
      end
      7: begin
        s.demand       = 10'($urandom_range(180, 720));
        s.contention   = 12'($urandom_range(0, 430));
        s.working_set  = 20'($urandom_range(0, 2100));
        s.game_cpu_now = 10'($urandom_range(0, 620));
        flavor = $urandom_range(0, 3);
        case (flavor)
          0: begin s.read_rate = rate_around(100 * MEBI); s.write_rate = rate_below(50); end
          1: begin s.read_rate = rate_below(100); s.write_rate = rate_around(50 * MEBI); end
          2: begin
            s.read_rate  = 40'($urandom_range(0, 600 * 1048576));
            s.write_rate = 40'($urandom_range(0, 600 * 1048576));
          end
          default: ;
        endcase
      end
      8: begin
        s.demand       = 10'($urandom_range(430, 470));
        s.contention   = 12'($urandom_range(260, 300));
        s.read_rate    = rate_around(50 * MEBI);
        s.write_rate   = rate_below(50);
        s.working_set  = 20'($urandom_range(1500, 1570));
      end
      9: begin
        s.demand      = 10'($urandom_range(0, 440));
        s.contention  = 12'($urandom_range(0, 270));
        s.read_rate   = rate_below(50);
        s.write_rate  = rate_below(50);
        s.working_set = 20'($urandom_range(0, 1530));
      end
      default: ;                                        // pure noise
    endcase
    return s;
  endfunction

  initial begin
    bit quiet;
    sb = new();
    cycle_count = 0;
    rst_n = 1'b0;
    start = 1'b0;
    {in_game_cpu_ewma, in_idle_flag, in_demand, in_stability, in_sustained_heavy,
     in_contention, in_system_cpu, in_background_cpu, in_game_cpu_now,
     in_working_set, in_read_rate, in_write_rate} = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    floors[0] = 10'd0;
    floors[1] = 10'd1023;                                // no verdict may ask for action
    floors[2] = 10'd1000;
    floors[3] = 10'd920;                                 // equals the top cpu confidence
    floors[4] = 10'($urandom_range(0, 1000));
    floors[5] = wbc_pkg::MIN_CONF_RESET;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed edge cases at the reset threshold, back to back
    for (int unsigned i = 0; i < DIRECTED_N; i++)
      send_sample(directed_sample(i));

    for (int unsigned p = 0; p < PHASES; p++) begin
      drain();
      write_floor(floors[p]);
      @(posedge clk);
      // one phase runs with no idling at all
      quiet = (p == 2);
      for (int unsigned i = 0; i < PHASE_ITEMS; i++) begin
        send_sample(random_sample());
        if (p == 4 && i == PHASE_ITEMS / 2)
          drain();
        else if (!quiet && $urandom_range(0, 99) < IDLE_PCT)
          hold_off($urandom_range(1, 2));
      end
    end

    drain();
    repeat (4) @(posedge clk);
    if (sb.pending() != 0)
      sb.report($sformatf("%0d expected results never arrived", sb.pending()));

    $display("covered %0d samples (%0d directed) over %0d threshold settings, %0d checked",
             sb.accepted, DIRECTED_N, PHASES + 1, sb.checked);
    $display({"verdicts: unknown %0d gpu %0d cpu %0d contention %0d memory %0d io %0d",
              " mixed %0d, %0d action requests"},
             sb.verdict_hits[0], sb.verdict_hits[1], sb.verdict_hits[2], sb.verdict_hits[3],
             sb.verdict_hits[4], sb.verdict_hits[5], sb.verdict_hits[6], sb.actions);
    if (sb.errors == 0) begin
      $display("workload_bottleneck_classifier_unit verification clean");
    end else begin
      $display("workload_bottleneck_classifier_unit verification failed");
    end
    $finish;
  end
endmodule
